@@ sv/sha1_byte_stream_hasher_macros.svh @@
// Assertion helpers shared by the hasher modules.
`ifndef SHA1_BYTE_STREAM_HASHER_MACROS_SVH
`define SHA1_BYTE_STREAM_HASHER_MACROS_SVH

`ifndef SYNTHESIS
// checked outside reset
`define SHABS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("shabs assertion failed");
// checked on every edge, reset included
`define SHABS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("shabs assertion failed");
`else
`define SHABS_ASSERT(lbl, prop)
`define SHABS_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

@@ sv/shabs_pkg.sv @@
package shabs_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam logic [QAW:0] QFULL = (QAW + 1)'(QDEPTH);

  localparam int NUM_WORDS = 5;

  typedef enum logic [1:0] {
    KIND_BYTE     = 2'd0,
    KIND_BYTE_END = 2'd1,
    KIND_END      = 2'd2
  } item_kind_e;

  typedef struct packed {
    item_kind_e  kind;
    logic [7:0]  data;
  } qitem_t;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [31:0] H_INIT [NUM_WORDS] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [7:0] PAD_MARK = 8'h80;

  function automatic logic [31:0] round_k(input logic [6:0] r);
    logic [31:0] k;
    if (r < 7'd20) begin
      k = K0;
    end else if (r < 7'd40) begin
      k = K1;
    end else if (r < 7'd60) begin
      k = K2;
    end else begin
      k = K3;
    end
    return k;
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (r < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (r < 7'd40) begin
      f = b ^ c ^ d;
    end else if (r < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

endpackage

@@ sv/shabs_front.sv @@
`include "sha1_byte_stream_hasher_macros.svh"

module shabs_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       data_byte_i,
  input  logic             has_byte_i,
  input  logic             end_of_message_i,
  output logic             q_valid_o,
  output shabs_pkg::qitem_t q_item_o,
  input  logic             q_pop_i
);
  import shabs_pkg::*;

  qitem_t         mem_q [QDEPTH];
  logic [QAW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QAW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QAW:0]   cnt_q, cnt_d;
  logic           take;
  logic           push;
  qitem_t         item;

  assign in_stall_o = (cnt_q == QFULL);
  assign take       = in_valid_i && !in_stall_o;
  // items with neither a byte nor an end mark are dropped here
  assign push       = take && (has_byte_i || end_of_message_i);

  always_comb begin
    item.data = data_byte_i;
    if (end_of_message_i) begin
      item.kind = has_byte_i ? KIND_BYTE_END : KIND_END;
    end else begin
      item.kind = KIND_BYTE;
    end
  end

  assign q_valid_o = (cnt_q != '0);
  assign q_item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (q_pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push && !q_pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && q_pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item;
    end
  end

  `SHABS_ASSERT(a_fill_bounded, cnt_q <= QFULL)
  `SHABS_ASSERT(a_pop_nonempty, q_pop_i |-> q_valid_o)
  `SHABS_ASSERT(a_fill_grows, (push && !q_pop_i) |=> (cnt_q == $past(cnt_q) + 1'b1))

endmodule

@@ sv/shabs_core.sv @@
`include "sha1_byte_stream_hasher_macros.svh"

module shabs_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  shabs_pkg::qitem_t q_item_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [31:0]      digest_word_o,
  output logic [2:0]       word_index_o,
  output logic             last_word_o
);
  import shabs_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PAD  = 2'd1;
  localparam logic [1:0] S_COMP = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]  state_q, state_d;
  logic [31:0] win_q  [16];
  logic [31:0] win_d  [16];
  logic [31:0] hash_q [NUM_WORDS];
  logic [31:0] hash_d [NUM_WORDS];
  logic [31:0] work_q [NUM_WORDS];
  logic [31:0] work_d [NUM_WORDS];
  logic [6:0]  round_q, round_d;
  logic [63:0] cnt_q, cnt_d;
  logic [63:0] len_q, len_d;
  logic        pad_q, pad_d;
  logic        mark_q, mark_d;
  logic        lenph_q, lenph_d;
  logic        fin_q, fin_d;
  logic [2:0]  widx_q, widx_d;
  logic        oval_q, oval_d;
  logic [31:0] oword_q, oword_d;
  logic [2:0]  oidx_q, oidx_d;

  logic [5:0]  pos;
  logic [63:0] cnt_inc;
  logic        it_has, it_end;
  logic        len_now;
  logic [5:0]  len_lsb;
  logic [7:0]  fill_byte;
  logic        abs_en;
  logic [7:0]  abs_byte;
  logic [4:0]  lane_lsb;
  logic [31:0] w;
  logic [31:0] tmp;
  logic        out_load;

  assign pos     = cnt_q[5:0];
  assign cnt_inc = cnt_q + 64'd1;

  always_comb begin
    case (q_item_i.kind)
      KIND_BYTE: begin
        it_has = 1'b1;
        it_end = 1'b0;
      end
      KIND_BYTE_END: begin
        it_has = 1'b1;
        it_end = 1'b1;
      end
      KIND_END: begin
        it_has = 1'b0;
        it_end = 1'b1;
      end
      default: begin
        it_has = 1'b0;
        it_end = 1'b0;
      end
    endcase
  end

  assign q_pop_o = (state_q == S_IDLE) && q_valid_i;

  // length field occupies the last eight bytes of the final block
  assign len_now   = !mark_q && (lenph_q || pos == 6'd56);
  assign len_lsb   = {~pos[2:0], 3'b000};
  assign fill_byte = mark_q ? PAD_MARK : (len_now ? len_q[len_lsb +: 8] : 8'h00);

  assign abs_en   = (state_q == S_PAD) || (q_pop_o && it_has);
  assign abs_byte = (state_q == S_PAD) ? fill_byte : q_item_i.data;
  assign lane_lsb = {~pos[1:0], 3'b000};

  // window holds W[t-16..t-1] from round 16 on, oldest at index 0
  assign w = (round_q < 7'd16) ? win_q[0] :
             {win_q[13][30:0] ^ win_q[8][30:0] ^ win_q[2][30:0] ^ win_q[0][30:0],
              win_q[13][31] ^ win_q[8][31] ^ win_q[2][31] ^ win_q[0][31]};
  assign tmp = {work_q[0][26:0], work_q[0][31:27]}
             + round_f(round_q, work_q[1], work_q[2], work_q[3])
             + work_q[4] + round_k(round_q) + w;

  assign out_load = (state_q == S_OUT) && (!oval_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    win_d   = win_q;
    hash_d  = hash_q;
    work_d  = work_q;
    round_d = round_q;
    cnt_d   = cnt_q;
    len_d   = len_q;
    pad_d   = pad_q;
    mark_d  = mark_q;
    lenph_d = lenph_q;
    fin_d   = fin_q;
    widx_d  = widx_q;
    oval_d  = oval_q;
    oword_d = oword_q;
    oidx_d  = oidx_q;

    if (oval_q && !out_stall_i) begin
      oval_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (q_valid_i && it_end) begin
          pad_d   = 1'b1;
          mark_d  = 1'b1;
          lenph_d = 1'b0;
          len_d   = (it_has ? cnt_inc : cnt_q) << 3;
          state_d = S_PAD;
        end
      end
      S_PAD: begin
        if (mark_q) begin
          mark_d = 1'b0;
        end else if (len_now) begin
          lenph_d = 1'b1;
        end
        if (pos == 6'd63 && len_now) begin
          fin_d = 1'b1;
        end
      end
      S_COMP: begin
        for (int i = 0; i < 15; i++) begin
          win_d[i] = win_q[i+1];
        end
        win_d[15] = w;
        work_d[4] = work_q[3];
        work_d[3] = work_q[2];
        work_d[2] = {work_q[1][1:0], work_q[1][31:2]};
        work_d[1] = work_q[0];
        work_d[0] = tmp;
        round_d   = round_q + 7'd1;
        if (round_q == 7'd79) begin
          round_d   = '0;
          hash_d[0] = hash_q[0] + tmp;
          hash_d[1] = hash_q[1] + work_q[0];
          hash_d[2] = hash_q[2] + {work_q[1][1:0], work_q[1][31:2]};
          hash_d[3] = hash_q[3] + work_q[2];
          hash_d[4] = hash_q[4] + work_q[3];
          if (fin_q) begin
            widx_d  = '0;
            state_d = S_OUT;
          end else if (pad_q) begin
            state_d = S_PAD;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_OUT: begin
        if (out_load) begin
          oval_d  = 1'b1;
          oword_d = hash_q[widx_q];
          oidx_d  = widx_q;
          widx_d  = widx_q + 3'd1;
          if (widx_q == 3'(NUM_WORDS - 1)) begin
            hash_d  = H_INIT;
            cnt_d   = '0;
            pad_d   = 1'b0;
            fin_d   = 1'b0;
            lenph_d = 1'b0;
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (abs_en) begin
      win_d[pos[5:2]][lane_lsb +: 8] = abs_byte;
      cnt_d = cnt_inc;
      // a full block starts the rounds
      if (pos == 6'd63) begin
        work_d  = hash_q;
        round_d = '0;
        state_d = S_COMP;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      hash_q  <= H_INIT;
      round_q <= '0;
      cnt_q   <= '0;
      pad_q   <= 1'b0;
      mark_q  <= 1'b0;
      lenph_q <= 1'b0;
      fin_q   <= 1'b0;
      widx_q  <= '0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      hash_q  <= hash_d;
      round_q <= round_d;
      cnt_q   <= cnt_d;
      pad_q   <= pad_d;
      mark_q  <= mark_d;
      lenph_q <= lenph_d;
      fin_q   <= fin_d;
      widx_q  <= widx_d;
      oval_q  <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q   <= win_d;
    work_q  <= work_d;
    len_q   <= len_d;
    oword_q <= oword_d;
    oidx_q  <= oidx_d;
  end

  assign out_valid_o   = oval_q;
  assign digest_word_o = oword_q;
  assign word_index_o  = oidx_q;
  assign last_word_o   = (oidx_q == 3'(NUM_WORDS - 1));

  `SHABS_ASSERT(a_round_range, (state_q == S_COMP) |-> (round_q < 7'd80))
  `SHABS_ASSERT(a_comp_on_full, $rose(state_q == S_COMP) |-> ($past(pos) == 6'd63))
  `SHABS_ASSERT(a_restart_after_digest,
    (out_load && widx_q == 3'(NUM_WORDS - 1)) |=> (cnt_q == 64'd0 && state_q == S_IDLE))

endmodule

@@ sv/sha1_byte_stream_hasher.sv @@
// SHA-1 hasher fed one message byte per input transfer.
// Input channel: in_valid_i / in_stall_o with data_byte_i, has_byte_i and
// end_of_message_i. An item with end_of_message_i set closes the message,
// after its byte if has_byte_i is set; an end item without a byte is valid
// and also covers the empty message.
// Output channel: out_valid_o / out_stall_i carrying five transfers per
// message: digest_word_o with word_index_o 0..4, last_word_o on index 4.
// A four-entry queue sits between the input and the hashing engine.
// Operation: a byte is absorbed as it leaves the queue; every 64th byte
// starts 80 rounds, one round per cycle in the shared round unit.
// Closing a message feeds padding and length one byte per cycle between
// compressions (9 to 72 bytes, with one or two compressions), then one
// digest word per cycle while the output is not stalled.
// The input stalls only when the queue is full.
// Reset clears the queue, loads the initial hash values and a zero count;
// no clearing pass is needed. A stalled output holds its word, and the
// engine waits on it while the queue keeps taking input.
module sha1_byte_stream_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        has_byte_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);
  import shabs_pkg::*;

  logic   q_valid;
  logic   q_pop;
  qitem_t q_item;

  shabs_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .has_byte_i       (has_byte_i),
    .end_of_message_i (end_of_message_i),
    .q_valid_o        (q_valid),
    .q_item_o         (q_item),
    .q_pop_i          (q_pop)
  );

  shabs_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_item_i      (q_item),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .digest_word_o (digest_word_o),
    .word_index_o  (word_index_o),
    .last_word_o   (last_word_o)
  );

endmodule
